### src/kcwl_pkg.sv
package kcwl_pkg;

    localparam logic [2:0] REQ_GET        = 3'd0;
    localparam logic [2:0] REQ_PUT        = 3'd1;
    localparam logic [2:0] REQ_FLUSH      = 3'd2;
    localparam logic [2:0] REQ_INVALIDATE = 3'd3;
    localparam logic [2:0] REQ_STATS      = 3'd4;

    localparam logic [15:0] WEIGHT_RESET = 16'd1000;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_ARG = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  key;
        logic [63:0] data_value;
        logic [63:0] timestamp;
    } t_req;

    typedef struct packed {
        logic        status;
        logic        hit;
        logic [63:0] read_value;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } t_rsp;

    typedef struct packed {
        logic [3:0]  key;
        logic [63:0] value;
        logic [63:0] last_use;
        logic [31:0] use_count;
    } t_entry;

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == COUNT_MAX) ? c : c + 32'd1;
    endfunction

endpackage

### src/keyed_cache_weighted_lru.sv
// channel  | signals                              | beat
// in       | i_in_valid / o_in_ready / i_in_data  | one request (t_req)
// out      | o_out_valid / i_out_ready / o_out_data | one response (t_rsp)
// cfg      | i_cfg_we / i_cfg_data                | frequency weight, no wait
//
// get and put sweep the entry memory one address a cycle, then write back once.
// flush, invalidate, stats, unused codes, a put of zero and any request with a
// key at or above KEY_COUNT skip the sweep and go straight to the write-back.
// the sweep length follows from the single read port of the entry memory.
// reset clears valid marks, counters, weight and control; no clearing pass.
// a held response stalls only the write-back; the sweep runs on regardless.
module keyed_cache_weighted_lru #(
    parameter int ENTRIES   = 16,
    parameter int KEY_COUNT = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  kcwl_pkg::t_req   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output kcwl_pkg::t_rsp   o_out_data,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data
);
    import kcwl_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state        r_state;
    t_req          r_req;
    t_rsp          r_out;
    logic          r_out_valid;
    logic [15:0]   r_weight;
    logic [31:0]   r_hits;
    logic [31:0]   r_misses;
    logic [ENTRIES-1:0] r_valid;
    logic [CW-1:0] r_cnt;
    logic          r_a_vld;
    logic [AW-1:0] r_a_idx;
    logic          r_match_found;
    logic [AW-1:0] r_match_idx;
    logic [63:0]   r_match_value;
    logic [31:0]   r_match_count;
    logic          r_free_found;
    logic [AW-1:0] r_free_idx;

    logic          accept;
    logic          in_key_ok;
    logic          key_ok;
    logic          needs_scan;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_entry        rd_data;
    logic          a_entry_valid;
    logic [AW-1:0] victim_idx;
    logic          fin_go;
    t_rsp          fin_rsp;
    logic          wr_en;
    logic [AW-1:0] wr_idx;
    t_entry        wr_data;
    logic          set_valid;
    logic          clr_valid;
    logic          clr_stats;
    logic          hit_inc;
    logic          miss_inc;

    assign accept    = i_in_valid && o_in_ready;
    assign in_key_ok = 32'(i_in_data.key) < KEY_COUNT;
    assign key_ok    = 32'(r_req.key) < KEY_COUNT;
    assign needs_scan = in_key_ok && ((i_in_data.req_type == REQ_GET) ||
                        (i_in_data.req_type == REQ_PUT && i_in_data.data_value != 64'd0));

    assign rd_en   = (r_state == S_SCAN) && (r_cnt < CW'(ENTRIES));
    assign rd_addr = r_cnt[AW-1:0];
    assign a_entry_valid = r_valid[r_a_idx];

    kcwl_mem #(
        .DEPTH (ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    kcwl_victim #(
        .AW (AW)
    ) u_victim (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_vld       (r_a_vld && a_entry_valid),
        .i_idx       (r_a_idx),
        .i_last_use  (rd_data.last_use),
        .i_use_count (rd_data.use_count),
        .i_weight    (r_weight),
        .o_idx       (victim_idx)
    );

    assign fin_go = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        fin_rsp   = '0;
        wr_en     = 1'b0;
        wr_idx    = r_match_idx;
        wr_data   = '{key: r_req.key, value: r_req.data_value,
                      last_use: r_req.timestamp, use_count: 32'd1};
        set_valid = 1'b0;
        clr_valid = 1'b0;
        clr_stats = 1'b0;
        hit_inc   = 1'b0;
        miss_inc  = 1'b0;
        case (r_req.req_type)
            REQ_GET: begin
                if (key_ok && r_match_found) begin
                    fin_rsp.hit        = 1'b1;
                    fin_rsp.read_value = r_match_value;
                    wr_en              = fin_go;
                    wr_data.value      = r_match_value;
                    wr_data.use_count  = sat_inc(r_match_count);
                    hit_inc            = fin_go;
                end else begin
                    miss_inc = fin_go;
                end
            end
            REQ_PUT: begin
                if (!key_ok || r_req.data_value == 64'd0) begin
                    fin_rsp.status = STATUS_BAD_ARG;
                end else begin
                    wr_en     = fin_go;
                    set_valid = fin_go;
                    if (r_match_found) begin
                        wr_data.use_count = sat_inc(r_match_count);
                    end else if (r_free_found) begin
                        wr_idx = r_free_idx;
                    end else begin
                        wr_idx = victim_idx;
                    end
                end
            end
            REQ_FLUSH: begin
                clr_valid = fin_go;
                clr_stats = fin_go;
            end
            REQ_INVALIDATE: begin
                clr_valid = fin_go;
            end
            REQ_STATS: begin
                fin_rsp.hit_total  = r_hits;
                fin_rsp.miss_total = r_misses;
            end
            default: begin
                fin_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_weight      <= WEIGHT_RESET;
            r_hits        <= '0;
            r_misses      <= '0;
            r_valid       <= '0;
            r_cnt         <= '0;
            r_a_vld       <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_weight <= i_cfg_data;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_a_vld <= rd_en;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cnt         <= '0;
                        r_match_found <= 1'b0;
                        r_free_found  <= 1'b0;
                        r_state       <= needs_scan ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + CW'(1);
                    // last read beat has cleared the score pipeline
                    if (r_cnt == CW'(ENTRIES + 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_a_vld && a_entry_valid && rd_data.key == r_req.key && !r_match_found) begin
                r_match_found <= 1'b1;
            end
            if (r_a_vld && !a_entry_valid && !r_free_found) begin
                r_free_found <= 1'b1;
            end
            if (hit_inc) begin
                r_hits <= r_hits + 32'd1;
            end
            if (miss_inc) begin
                r_misses <= r_misses + 32'd1;
            end
            if (clr_stats) begin
                r_hits   <= '0;
                r_misses <= '0;
            end
            if (clr_valid) begin
                r_valid <= '0;
            end else if (set_valid) begin
                r_valid[wr_idx] <= 1'b1;
            end
        end
        if (accept) begin
            r_req <= i_in_data;
        end
        if (fin_go) begin
            r_out <= fin_rsp;
        end
        if (r_a_vld && a_entry_valid && rd_data.key == r_req.key && !r_match_found) begin
            r_match_idx   <= r_a_idx;
            r_match_value <= rd_data.value;
            r_match_count <= rd_data.use_count;
        end
        if (r_a_vld && !a_entry_valid && !r_free_found) begin
            r_free_idx <= r_a_idx;
        end
        r_a_idx <= rd_addr;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // a remembered match always points at a live entry
    a_match_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match_found |-> r_valid[r_match_idx])
        else $error("match index refers to an invalid entry");

    // a miss never carries a value
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hit) |-> (o_out_data.read_value == 64'd0))
        else $error("read value without a hit");

    // hit counter moves by one on a get hit write-back
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit_inc |=> (r_hits == $past(r_hits) + 32'd1))
        else $error("hit counter not bumped");

    // a put write-back leaves its entry valid
    a_put_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_valid |=> r_valid[$past(wr_idx)])
        else $error("written entry not marked valid");

endmodule

### src/kcwl_mem.sv
module kcwl_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  kcwl_pkg::t_entry      i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output kcwl_pkg::t_entry      o_rdata
);
    import kcwl_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/kcwl_victim.sv
module kcwl_victim #(
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_vld,
    input  logic [AW-1:0] i_idx,
    input  logic [63:0]   i_last_use,
    input  logic [31:0]   i_use_count,
    input  logic [15:0]   i_weight,
    output logic [AW-1:0] o_idx
);
    import kcwl_pkg::*;

    logic          r_b_vld;
    logic [AW-1:0] r_b_idx;
    logic [63:0]   r_b_last;
    logic [47:0]   r_b_prod;
    logic          r_found;
    logic [63:0]   r_best_score;
    logic [AW-1:0] r_best_idx;
    logic [63:0]   score;

    // score wraps modulo 2^64
    assign score = r_b_last - {16'd0, r_b_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_b_vld <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_b_vld <= i_vld;
            // strict compare keeps the lowest index on ties
            if (r_b_vld && (!r_found || score < r_best_score)) begin
                r_found <= 1'b1;
            end
        end
        r_b_idx  <= i_idx;
        r_b_last <= i_last_use;
        r_b_prod <= 48'(i_use_count) * 48'(i_weight);
        if (r_b_vld && (!r_found || score < r_best_score)) begin
            r_best_score <= score;
            r_best_idx   <= r_b_idx;
        end
    end

    assign o_idx = r_best_idx;

endmodule
